FILE: src/slrp_pkg.sv
// ---------------------------------------------------------------------------
// slrp_pkg: shared definitions of the latency route predictor
// Field widths, register indexes, command codes, controller state type and
// the command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package slrp_pkg;

    // default sizes
    localparam int NUM_ROUTES_DEF = 3;
    localparam int SUM_WIDTH_DEF  = 48;

    // field widths
    localparam int ROUTE_W   = 2;
    localparam int LATENCY_W = 32;
    localparam int CFG_W     = 16;
    localparam int PHASE_W   = 16;
    localparam int FLUSH_W   = 32;

    // stream word widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    // configuration port
    localparam int               CFG_ADDR_W        = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SNIFF_PERIOD  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FLUSH_SPAN    = 2'd1;
    localparam logic [CFG_W-1:0] SNIFF_PERIOD_RST  = 16'd16;
    localparam logic [CFG_W-1:0] FLUSH_SPAN_RST    = 16'd8;

    // input command codes
    localparam logic CMD_NEW_PACKET   = 1'b0;
    localparam logic CMD_SNIFF_RETURN = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FLUSH,
        ST_SCAN_NORM,
        ST_LOG,
        ST_APPLY,
        ST_SCAN_PRED,
        ST_EMIT
    } slrp_state_t;

    // controller to datapath
    typedef struct packed {
        logic item_load;
        logic exec;
        logic flush_step;
        logic scan_step;
        logic lz_step;
        logic apply_step;
        logic emit;
    } slrp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic new_packet;
        logic flush_due;
        logic idx_last;
        logic lz_done;
        logic out_free;
    } slrp_status_t;

endpackage

FILE: src/slrp_ctrl.sv
// ---------------------------------------------------------------------------
// slrp_ctrl: sequencing controller
// Walks one word through update, optional normalisation, best-route scan and
// hand-over to the output register.
// ---------------------------------------------------------------------------
module slrp_ctrl
    import slrp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  slrp_status_t status,
    output slrp_cmd_t    cmd
);

    slrp_state_t state_reg;
    slrp_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = status.new_packet ? ST_FLUSH : ST_SCAN_PRED;
            end
            ST_FLUSH: begin
                state_next = status.flush_due ? ST_SCAN_NORM : ST_SCAN_PRED;
            end
            ST_SCAN_NORM: begin
                if (status.idx_last) begin
                    state_next = ST_LOG;
                end
            end
            ST_LOG: begin
                if (status.lz_done) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (status.idx_last) begin
                    state_next = ST_SCAN_PRED;
                end
            end
            ST_SCAN_PRED: begin
                if (status.idx_last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.item_load = s_tvalid;
            end
            ST_EXEC:      cmd.exec       = 1'b1;
            ST_FLUSH:     cmd.flush_step = 1'b1;
            ST_SCAN_NORM: cmd.scan_step  = 1'b1;
            ST_LOG:       cmd.lz_step    = !status.lz_done;
            ST_APPLY:     cmd.apply_step = 1'b1;
            ST_SCAN_PRED: cmd.scan_step  = 1'b1;
            ST_EMIT:      cmd.emit       = status.out_free;
            default:      cmd            = '0;
        endcase
    end

endmodule

FILE: src/slrp_datapath.sv
// ---------------------------------------------------------------------------
// slrp_datapath: counters, latency sums and result register
// Holds the configuration, packet phase counters, saturating route sums, the
// shared minimum scan, the shift-count search and the output register.
// ---------------------------------------------------------------------------
module slrp_datapath
    import slrp_pkg::*;
#(
    parameter int NUM_ROUTES = NUM_ROUTES_DEF,
    parameter int SUM_WIDTH  = SUM_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  slrp_cmd_t             cmd,
    output slrp_status_t          status
);

    localparam int IDX_W     = $clog2(NUM_ROUTES);
    localparam int CNT_W     = $clog2(SUM_WIDTH);
    localparam int SUM_EXT_W = SUM_WIDTH + 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_ROUTES - 1);

    // configuration
    logic [CFG_W-1:0] sniff_period_reg;
    logic [CFG_W-1:0] flush_span_reg;

    // captured word
    logic                 item_cmd_reg,     item_cmd_next;
    logic [ROUTE_W-1:0]   item_route_reg,   item_route_next;
    logic [LATENCY_W-1:0] item_latency_reg, item_latency_next;

    // packet counters
    logic [PHASE_W-1:0] period_phase_reg,   period_phase_next;
    logic [IDX_W-1:0]   rotation_index_reg, rotation_index_next;
    logic [FLUSH_W-1:0] flush_phase_reg,    flush_phase_next;
    logic [FLUSH_W-1:0] flush_len_reg,      flush_len_next;

    // route sums
    logic [SUM_WIDTH-1:0] sum_reg  [NUM_ROUTES];
    logic [SUM_WIDTH-1:0] sum_next [NUM_ROUTES];

    // scan and shift search
    logic [IDX_W-1:0]     idx_reg,    idx_next;
    logic [SUM_WIDTH-1:0] min_reg,    min_next;
    logic [IDX_W-1:0]     best_reg,   best_next;
    logic [CNT_W-1:0]     lz_cnt_reg, lz_cnt_next;

    // pending result fields
    logic             res_sniff_reg,    res_sniff_next;
    logic [IDX_W-1:0] res_assigned_reg, res_assigned_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg,  out_data_next;

    logic [CFG_W-1:0]     eff_period;
    logic [CFG_W-1:0]     eff_flush;
    logic [PHASE_W:0]     period_inc;
    logic [FLUSH_W:0]     flush_inc;
    logic                 route_ok;
    logic [IDX_W-1:0]     route_idx;
    logic [IDX_W-1:0]     rd_addr;
    logic [SUM_WIDTH-1:0] sum_rd;
    logic [SUM_EXT_W-1:0] sum_add;

    // zero registers act as one
    assign eff_period = (sniff_period_reg == '0) ? CFG_W'(1) : sniff_period_reg;
    assign eff_flush  = (flush_span_reg == '0) ? CFG_W'(1) : flush_span_reg;

    assign period_inc = (PHASE_W + 1)'(period_phase_reg) + (PHASE_W + 1)'(1);
    assign flush_inc  = (FLUSH_W + 1)'(flush_phase_reg) + (FLUSH_W + 1)'(1);

    assign route_ok  = 4'(item_route_reg) < 4'(NUM_ROUTES);
    assign route_idx = IDX_W'(item_route_reg);

    // single read port on the sums
    assign rd_addr = cmd.exec ? route_idx : idx_reg;
    assign sum_rd  = sum_reg[rd_addr];
    assign sum_add = SUM_EXT_W'(sum_rd) + SUM_EXT_W'(item_latency_reg);

    // status to controller
    assign status.new_packet = (item_cmd_reg == CMD_NEW_PACKET);
    assign status.flush_due  = flush_inc >= (FLUSH_W + 1)'(flush_len_reg);
    assign status.idx_last   = (idx_reg == IDX_LAST);
    assign status.lz_done    = (min_reg <= SUM_WIDTH'(1));
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sniff_period_reg <= SNIFF_PERIOD_RST;
            flush_span_reg   <= FLUSH_SPAN_RST;
        end else if (cfg_we) begin
            if (cfg_addr == CFG_SNIFF_PERIOD) begin
                sniff_period_reg <= cfg_wdata;
            end
            if (cfg_addr == CFG_FLUSH_SPAN) begin
                flush_span_reg <= cfg_wdata;
            end
        end
    end

    // next values
    always_comb begin
        item_cmd_next       = item_cmd_reg;
        item_route_next     = item_route_reg;
        item_latency_next   = item_latency_reg;
        period_phase_next   = period_phase_reg;
        rotation_index_next = rotation_index_reg;
        flush_phase_next    = flush_phase_reg;
        flush_len_next      = flush_len_reg;
        sum_next            = sum_reg;
        idx_next            = idx_reg;
        min_next            = min_reg;
        best_next           = best_reg;
        lz_cnt_next         = lz_cnt_reg;
        res_sniff_next      = res_sniff_reg;
        res_assigned_next   = res_assigned_reg;
        out_valid_next      = out_valid_reg;
        out_data_next       = out_data_reg;

        // capture the accepted word
        if (cmd.item_load) begin
            item_cmd_next     = s_tuser;
            item_route_next   = s_tdata[ROUTE_W-1:0];
            item_latency_next = s_tdata[ROUTE_W +: LATENCY_W];
        end

        // packet count or sum update
        if (cmd.exec) begin
            res_sniff_next    = 1'b0;
            res_assigned_next = '0;
            if (item_cmd_reg == CMD_NEW_PACKET) begin
                flush_len_next = FLUSH_W'(32'(eff_flush) * 32'(eff_period));
                if (period_phase_reg == '0) begin
                    res_sniff_next    = 1'b1;
                    res_assigned_next = rotation_index_reg;
                end
                if (period_inc >= (PHASE_W + 1)'(eff_period)) begin
                    period_phase_next   = '0;
                    rotation_index_next = (rotation_index_reg == IDX_LAST) ? '0
                                        : rotation_index_reg + IDX_W'(1);
                end else begin
                    period_phase_next = period_inc[PHASE_W-1:0];
                end
            end else if (route_ok) begin
                // saturate on carry out
                sum_next[route_idx] = sum_add[SUM_WIDTH] ? '1 : sum_add[SUM_WIDTH-1:0];
            end
        end

        // flush counter
        if (cmd.flush_step) begin
            if (status.flush_due) begin
                flush_phase_next = '0;
                lz_cnt_next      = '0;
            end else begin
                flush_phase_next = flush_inc[FLUSH_W-1:0];
            end
        end

        // minimum scan, lowest index wins ties
        if (cmd.scan_step) begin
            if (idx_reg == '0 || sum_rd < min_reg) begin
                min_next  = sum_rd;
                best_next = idx_reg;
            end
        end

        // shift count of the minimum
        if (cmd.lz_step) begin
            min_next    = min_reg >> 1;
            lz_cnt_next = lz_cnt_reg + CNT_W'(1);
        end

        // scale one sum down
        if (cmd.apply_step) begin
            sum_next[idx_reg] = sum_rd >> lz_cnt_reg;
        end

        // route pointer for scan and scaling
        if (cmd.scan_step || cmd.apply_step) begin
            idx_next = status.idx_last ? '0 : idx_reg + IDX_W'(1);
        end

        // output register
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit) begin
            out_valid_next = 1'b1;
            out_data_next  = {3'b000, ROUTE_W'(best_reg), ROUTE_W'(res_assigned_reg),
                              res_sniff_reg};
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_phase_reg   <= '0;
            rotation_index_reg <= '0;
            flush_phase_reg    <= '0;
            idx_reg            <= '0;
            out_valid_reg      <= 1'b0;
            for (int r = 0; r < NUM_ROUTES; r++) begin
                sum_reg[r] <= '0;
            end
        end else begin
            period_phase_reg   <= period_phase_next;
            rotation_index_reg <= rotation_index_next;
            flush_phase_reg    <= flush_phase_next;
            idx_reg            <= idx_next;
            out_valid_reg      <= out_valid_next;
            sum_reg            <= sum_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        item_cmd_reg     <= item_cmd_next;
        item_route_reg   <= item_route_next;
        item_latency_reg <= item_latency_next;
        flush_len_reg    <= flush_len_next;
        min_reg          <= min_next;
        best_reg         <= best_next;
        lz_cnt_reg       <= lz_cnt_next;
        res_sniff_reg    <= res_sniff_next;
        res_assigned_reg <= res_assigned_next;
        out_data_reg     <= out_data_next;
    end

    // a new packet leaves the phase below the period
    a_phase_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && status.new_packet) |=> (period_phase_reg < eff_period))
        else $error("period phase not below sniff period");

    // the shift search stops before the sum width
    a_shift_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.lz_step |-> (lz_cnt_reg < CNT_W'(SUM_WIDTH - 1)))
        else $error("normalisation shift count overrun");

    // a result is only loaded into a free output register
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!out_valid_reg || m_tready))
        else $error("result overwrote a pending word");

endmodule

FILE: src/sniffing_latency_route_predictor.sv
// ---------------------------------------------------------------------------
// sniffing_latency_route_predictor: latency based memory route predictor
// Marks sniffer packets, keeps per-route latency sums and predicts the route
// with the smallest sum.
// ---------------------------------------------------------------------------
// One word is handled at a time. Each word passes the update and the
// one-route-per-cycle minimum scan over the sum registers, and a new-packet
// word also a flush-counter step. A new packet that closes a flush interval
// adds a second scan, a shift-count search of one bit per cycle and a
// scaling pass over the routes. The result sits in an output register;
// the next word may be accepted while it waits, but its own result is held
// until that register is free. Sums reset to zero with the block, no clearing
// pass is needed.
module sniffing_latency_route_predictor
    import slrp_pkg::*;
#(
    parameter int NUM_ROUTES = NUM_ROUTES_DEF,
    parameter int SUM_WIDTH  = SUM_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // route[1:0], latency[33:2], zero pad
    input  logic                  s_tuser,  // command
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata   // sniff[0], sniff_route[2:1],
                                            // best_route[4:3], zero pad
);

    slrp_cmd_t    cmd;
    slrp_status_t status;

    slrp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    slrp_datapath #(
        .NUM_ROUTES (NUM_ROUTES),
        .SUM_WIDTH  (SUM_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking bench of the sniffing latency route predictor
// Drives new-packet and sniffer-return words through the input stream,
// predicts every result word from its own copy of the phase counters and
// latency sums, and checks each word on the result stream in order. Runs a
// directed part, a short run of maximal latencies and randomised phases with
// idling.
// ---------------------------------------------------------------------------
module tb;
    import slrp_pkg::*;

    localparam int ROUTES = NUM_ROUTES_DEF;
    localparam int SUM_W  = SUM_WIDTH_DEF;
    localparam logic [SUM_W-1:0]     SUM_TOP = {SUM_W{1'b1}};
    localparam logic [LATENCY_W-1:0] LAT_TOP = {LATENCY_W{1'b1}};

    // route codes
    localparam logic [ROUTE_W-1:0] ROUTE_DRAM     = 2'd0;
    localparam logic [ROUTE_W-1:0] ROUTE_L2C_DRAM = 2'd1;
    localparam logic [ROUTE_W-1:0] ROUTE_LLC_DRAM = 2'd2;
    localparam logic [ROUTE_W-1:0] ROUTE_BAD      = 2'd3;

    // indexes with no register behind them
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 80;
    localparam int REPORT_MAX    = 10;
    localparam int BIG_RETURNS   = 12;
    localparam int PHASE_WORDS   = 228;

    // one result word, sniff in the lowest bit
    typedef struct packed {
        logic [ROUTE_W-1:0] predicted;
        logic [ROUTE_W-1:0] assigned;
        logic               sniff;
    } route_result_t;

    // predictor of the route choice plus the queue of expected result words
    class route_tracker;
        logic [CFG_W-1:0]   sniff_period;
        logic [CFG_W-1:0]   flush_span;
        logic [PHASE_W-1:0] period_phase;
        logic [ROUTE_W-1:0] rotation;
        logic [FLUSH_W-1:0] flush_phase;
        logic [SUM_W-1:0]   sums [ROUTES];
        route_result_t      expected_routes [$];
        int                 failures;

        function new();
            sniff_period = SNIFF_PERIOD_RST;
            flush_span   = FLUSH_SPAN_RST;
            period_phase = '0;
            rotation     = '0;
            flush_phase  = '0;
            foreach (sums[r]) sums[r] = '0;
            failures = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_W-1:0] data);
            if (addr == CFG_SNIFF_PERIOD)
                sniff_period = data;
            else if (addr == CFG_FLUSH_SPAN)
                flush_span = data;
        endfunction

        // smallest sum, lowest route on ties
        function logic [ROUTE_W-1:0] cheapest_route();
            logic [ROUTE_W-1:0] best;
            best = '0;
            for (int r = 1; r < ROUTES; r++)
                if (sums[r] < sums[best]) best = ROUTE_W'(r);
            return best;
        endfunction

        // halve the smallest sum down to at most one, shift the rest alike
        function void rescale_sums();
            logic [SUM_W-1:0] low;
            int               shift;
            low   = sums[cheapest_route()];
            shift = 0;
            while (low > 1) begin
                low = low >> 1;
                shift++;
            end
            foreach (sums[r]) sums[r] = sums[r] >> shift;
        endfunction

        function void note_word(logic cmd, logic [ROUTE_W-1:0] route,
                                logic [LATENCY_W-1:0] lat);
            route_result_t      res;
            logic [CFG_W-1:0]   period;
            logic [CFG_W-1:0]   flush_mult;
            logic [FLUSH_W-1:0] flush_len;
            logic [SUM_W:0]     total;
            res = '0;
            if (cmd == CMD_NEW_PACKET) begin
                // a zero register acts as one
                period     = (sniff_period == 0) ? CFG_W'(1) : sniff_period;
                flush_mult = (flush_span == 0) ? CFG_W'(1) : flush_span;
                flush_len  = FLUSH_W'(period) * FLUSH_W'(flush_mult);
                if (period_phase == 0) begin
                    res.sniff    = 1'b1;
                    res.assigned = rotation;
                end
                // phases past a lowered bound wrap on the next packet
                if (int'(period_phase) + 1 >= int'(period)) begin
                    period_phase = '0;
                    rotation = (int'(rotation) + 1 >= ROUTES) ? '0 : rotation + 1'b1;
                end else begin
                    period_phase = period_phase + 1'b1;
                end
                if ({1'b0, flush_phase} + 33'd1 >= {1'b0, flush_len}) begin
                    flush_phase = '0;
                    rescale_sums();
                end else begin
                    flush_phase = flush_phase + 1'b1;
                end
            end else if (int'(route) < ROUTES) begin
                // saturating accumulate
                total = {1'b0, sums[route]} + lat;
                sums[route] = (total > {1'b0, SUM_TOP}) ? SUM_TOP : total[SUM_W-1:0];
            end
            res.predicted = cheapest_route();
            expected_routes.push_back(res);
        endfunction

        function void check_word(logic [M_TDATA_W-1:0] word);
            route_result_t got;
            route_result_t want;
            got = word[4:0];
            if (expected_routes.size() == 0) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("result word %h arrived with none pending", word);
                return;
            end
            want = expected_routes.pop_front();
            if (got !== want) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("mismatch: sniff exp %0d got %0d, %s %0d got %0d, %s %0d got %0d",
                             want.sniff, got.sniff, "assigned exp",
                             want.assigned, got.assigned,
                             "predicted exp", want.predicted, got.predicted);
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // route[1:0], latency[33:2], zero pad
    logic                  s_tuser;   // command
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;   // sniff[0], sniff_route[2:1],
                                      // best_route[4:3], zero pad

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count;

    route_tracker book;

    sniffing_latency_route_predictor DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) book.check_word(m_tdata);
    end

    // entered and left at a falling edge; valid stays high on exit
    task automatic send_word(input logic cmd, input logic [ROUTE_W-1:0] route,
                             input logic [LATENCY_W-1:0] lat);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_TDATA_W - LATENCY_W - ROUTE_W){1'b0}}, lat, route};
        do @(posedge aclk); while (!s_tready);
        book.note_word(cmd, route, lat);
        @(negedge aclk);
    endtask

    // hold the sender until every pending word is back and the block settles
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (book.expected_routes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        book.write_reg(addr, data);
        @(negedge aclk);
    endtask

    // one randomised phase under a fixed setting and idling mix
    task automatic run_phase(input logic [CFG_W-1:0] period, input logic [CFG_W-1:0] flush,
                             input int send_pct, input int recv_pct, input int count);
        logic                 cmd;
        logic [ROUTE_W-1:0]   route;
        logic [LATENCY_W-1:0] lat;
        drain_results();
        write_reg(CFG_SNIFF_PERIOD, period);
        write_reg(CFG_FLUSH_SPAN, flush);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int n = 0; n < count; n++) begin
            // now and then let every result come home first
            if ($urandom_range(0, 149) == 0) drain_results();
            cmd   = ($urandom_range(0, 99) < 55) ? CMD_NEW_PACKET : CMD_SNIFF_RETURN;
            route = ($urandom_range(0, 19) == 0) ? ROUTE_BAD
                                                 : ROUTE_W'($urandom_range(0, ROUTES - 1));
            case ($urandom_range(0, 9))
                0:       lat = '0;
                1:       lat = LAT_TOP;
                2, 3:    lat = $urandom();
                default: lat = LATENCY_W'($urandom_range(1, 2000));
            endcase
            send_word(cmd, route, lat);
        end
    endtask

    // cycle limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        book      = new();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_NEW_PACKET;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: first packet sniffs on route 0
        send_word(CMD_NEW_PACKET, ROUTE_DRAM, '0);
        // latency extremes on each route, ties, out-of-range route ignored
        send_word(CMD_SNIFF_RETURN, ROUTE_DRAM, LAT_TOP);
        send_word(CMD_SNIFF_RETURN, ROUTE_L2C_DRAM, '0);
        send_word(CMD_SNIFF_RETURN, ROUTE_LLC_DRAM, 32'd1);
        send_word(CMD_SNIFF_RETURN, ROUTE_BAD, LAT_TOP);
        send_word(CMD_SNIFF_RETURN, ROUTE_BAD, 32'h5A5A_A5A5);
        send_word(CMD_NEW_PACKET, ROUTE_BAD, LAT_TOP);

        // zero registers act as one: every packet sniffs and normalises
        drain_results();
        write_reg(CFG_SNIFF_PERIOD, '0);
        write_reg(CFG_FLUSH_SPAN, '0);
        repeat (3) send_word(CMD_NEW_PACKET, ROUTE_DRAM, '0);
        send_word(CMD_SNIFF_RETURN, ROUTE_L2C_DRAM, 32'd1000);
        send_word(CMD_NEW_PACKET, ROUTE_DRAM, '0);

        // sniff period lowered under the running phase
        drain_results();
        write_reg(CFG_SNIFF_PERIOD, 16'd16);
        write_reg(CFG_FLUSH_SPAN, 16'hFFFF);
        repeat (4) send_word(CMD_NEW_PACKET, ROUTE_DRAM, '0);
        send_word(CMD_SNIFF_RETURN, ROUTE_LLC_DRAM, 32'd7);
        drain_results();
        write_reg(CFG_SNIFF_PERIOD, 16'd3);
        repeat (2) send_word(CMD_NEW_PACKET, ROUTE_DRAM, '0);

        // flush length lowered under the running phase
        drain_results();
        write_reg(CFG_FLUSH_SPAN, 16'd1);
        send_word(CMD_NEW_PACKET, ROUTE_DRAM, '0);

        // maximal returns build large sums
        drain_results();
        write_reg(CFG_SNIFF_PERIOD, 16'hFFFF);
        write_reg(CFG_FLUSH_SPAN, 16'hFFFF);
        repeat (BIG_RETURNS) send_word(CMD_SNIFF_RETURN, ROUTE_L2C_DRAM, LAT_TOP);
        send_word(CMD_SNIFF_RETURN, ROUTE_LLC_DRAM, LAT_TOP);
        send_word(CMD_NEW_PACKET, ROUTE_DRAM, '0);

        // writes to unmapped indexes change nothing
        drain_results();
        write_reg(CFG_SPARE_LO, CFG_W'($urandom()));
        write_reg(CFG_SPARE_HI, CFG_W'($urandom()));

        // randomised phases
        run_phase(16'd1, 16'd1, 0, 0, PHASE_WORDS);
        run_phase(16'd2, 16'd3, 52, 0, PHASE_WORDS);
        run_phase(16'd4, 16'd2, 0, 52, PHASE_WORDS);
        run_phase(16'd3, 16'd0, 23, 23, PHASE_WORDS);
        run_phase(16'd0, 16'd5, 0, 0, PHASE_WORDS);
        run_phase(CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(1, 6)), 52, 0,
                  PHASE_WORDS);
        run_phase(16'hFFFF, 16'd1, 0, 52, PHASE_WORDS);
        run_phase(CFG_W'($urandom_range(1, 40)), 16'hFFFF, 23, 23, PHASE_WORDS);

        drain_results();
        if (book.failures == 0 && book.expected_routes.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: sniffing_latency_route_predictor.f
src/slrp_pkg.sv
src/slrp_ctrl.sv
src/slrp_datapath.sv
src/sniffing_latency_route_predictor.sv
dv/tb.sv
